>>> design/wsc_pkg.sv
// shared types and constants for the wavetable sound channel
// no dependencies; used by wsc_sample_out, the top level, the checker and the testbench
package wsc_pkg;

    // action codes carried by an input beat
    typedef enum logic [1:0] {
        ACT_READ   = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_TICK   = 2'd2,
        ACT_LENGTH = 2'd3
    } t_action;

    // register map, low address byte
    localparam logic [7:0] ADDR_DAC       = 8'h1A;
    localparam logic [7:0] ADDR_LENGTH    = 8'h1B;
    localparam logic [7:0] ADDR_VOLUME    = 8'h1C;
    localparam logic [7:0] ADDR_FREQ_LO   = 8'h1D;
    localparam logic [7:0] ADDR_FREQ_HI   = 8'h1E;
    localparam logic [7:0] ADDR_WAVE_LO   = 8'h30;
    localparam logic [7:0] ADDR_WAVE_HI   = 8'h3F;

    localparam int unsigned WAVE_BYTES    = 16;
    localparam int unsigned WAVE_AW       = $clog2(WAVE_BYTES);
    localparam int unsigned POS_W         = WAVE_AW + 1;

    localparam logic [7:0]  READ_IDLE     = 8'hFF;
    localparam logic [8:0]  LENGTH_FULL   = 9'd256;
    localparam logic [11:0] PERIOD_BASE   = 12'd2048;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] reg_address;
        logic [7:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic [3:0] sample_out;
        logic       channel_active;
    } t_out_item;

    // voice state that selects and scales the current sample
    typedef struct packed {
        logic             dac_on;
        logic             channel_on;
        logic [1:0]       volume_code;
        logic [POS_W-1:0] position;
    } t_voice_ctrl;

endpackage

>>> design/wsc_stream_if.sv
// valid/ready channel carrying one payload beat
// depends on nothing; payload type is given by the instantiating code
interface wsc_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> design/wavetable_sound_channel.sv
// wavetable sound channel: 32 four-bit samples, length counter, period timer
// result registered, offered the cycle after the input beat is accepted; one beat accepted per cycle
// while input stays ready, which it does while the result register is empty or being drained
// reset (synchronous, active low) clears the voice state, the result valid flag and the 16-byte wave ram
// depends on wsc_pkg, wsc_stream_if and wsc_sample_out
module wavetable_sound_channel (
    input  logic i_clk,
    input  logic i_rst_n,
    wsc_stream_if.sink   i_in,
    wsc_stream_if.source o_out
);
    localparam int unsigned AW = wsc_pkg::WAVE_AW;
    localparam int unsigned PW = wsc_pkg::POS_W;

    logic          r_dac_on,    n_dac_on;
    logic          r_chan_on,   n_chan_on;
    logic          r_len_en,    n_len_en;
    logic [8:0]    r_len_cnt,   n_len_cnt;
    logic [1:0]    r_vol,       n_vol;
    logic [10:0]   r_period,    n_period;
    logic [11:0]   r_timer,     n_timer;
    logic [PW-1:0] r_pos,       n_pos;
    logic [7:0]    r_wave [wsc_pkg::WAVE_BYTES];

    logic                 r_out_valid;
    wsc_pkg::t_out_item   r_out;

    wsc_pkg::t_in_item    item;
    wsc_pkg::t_voice_ctrl voice;
    logic                 accept;
    logic                 wave_we;
    logic [7:0]           rd_data;
    logic [7:0]           cur_byte;
    logic [3:0]           sample;
    logic [11:0]          reload_half;
    logic [12:0]          reload_dec;

    assign item      = i_in.payload;
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept    = i_in.valid && i_in.ready;

    assign reload_half = wsc_pkg::PERIOD_BASE - {1'b0, r_period};
    assign reload_dec  = {reload_half, 1'b0} - 13'd1;

    always_comb begin
        n_dac_on  = r_dac_on;
        n_chan_on = r_chan_on;
        n_len_en  = r_len_en;
        n_len_cnt = r_len_cnt;
        n_vol     = r_vol;
        n_period  = r_period;
        n_timer   = r_timer;
        n_pos     = r_pos;
        wave_we   = 1'b0;
        rd_data   = wsc_pkg::READ_IDLE;
        case (item.action)
            wsc_pkg::ACT_READ: begin
                case (item.reg_address)
                    wsc_pkg::ADDR_DAC:     rd_data = {r_dac_on, 7'h7F};
                    wsc_pkg::ADDR_VOLUME:  rd_data = {1'b1, r_vol, 5'h1F};
                    wsc_pkg::ADDR_FREQ_HI: rd_data = {1'b1, r_len_en, 6'h3F};
                    default: begin
                        if (item.reg_address inside
                                {[wsc_pkg::ADDR_WAVE_LO:wsc_pkg::ADDR_WAVE_HI]}) begin
                            rd_data = r_wave[item.reg_address[AW-1:0]];
                        end
                    end
                endcase
            end
            wsc_pkg::ACT_WRITE: begin
                case (item.reg_address)
                    wsc_pkg::ADDR_DAC: begin
                        n_dac_on = item.write_data[7];
                        if (!item.write_data[7]) begin
                            n_chan_on = 1'b0;
                        end
                    end
                    wsc_pkg::ADDR_LENGTH: begin
                        n_len_cnt = wsc_pkg::LENGTH_FULL - {1'b0, item.write_data};
                    end
                    wsc_pkg::ADDR_VOLUME:  n_vol = item.write_data[6:5];
                    wsc_pkg::ADDR_FREQ_LO: n_period[7:0] = item.write_data;
                    wsc_pkg::ADDR_FREQ_HI: begin
                        n_period[10:8] = item.write_data[2:0];
                        n_len_en       = item.write_data[6];
                        // trigger only counts while the dac is on
                        if (item.write_data[7] && r_dac_on) begin
                            n_chan_on = 1'b1;
                            if (r_len_cnt == 9'd0) begin
                                n_len_cnt = wsc_pkg::LENGTH_FULL;
                            end
                        end
                    end
                    default: begin
                        if (item.reg_address inside
                                {[wsc_pkg::ADDR_WAVE_LO:wsc_pkg::ADDR_WAVE_HI]}) begin
                            wave_we = 1'b1;
                        end
                    end
                endcase
            end
            wsc_pkg::ACT_TICK: begin
                if (r_timer == 12'd0) begin
                    // reload of 4096 at period zero fits the 12-bit timer after the decrement
                    n_timer = reload_dec[11:0];
                    n_pos   = r_pos + PW'(1);
                end else begin
                    n_timer = r_timer - 12'd1;
                end
            end
            wsc_pkg::ACT_LENGTH: begin
                if (r_len_en && (r_len_cnt != 9'd0)) begin
                    n_len_cnt = r_len_cnt - 9'd1;
                    if (r_len_cnt == 9'd1) begin
                        n_chan_on = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    // sample seen after this beat, with a same-beat wave write forwarded
    always_comb begin
        if (wave_we && (item.reg_address[AW-1:0] == n_pos[PW-1:1])) begin
            cur_byte = item.write_data;
        end else begin
            cur_byte = r_wave[n_pos[PW-1:1]];
        end
        voice.dac_on      = n_dac_on;
        voice.channel_on  = n_chan_on;
        voice.volume_code = n_vol;
        voice.position    = n_pos;
    end

    wsc_sample_out u_sample (
        .i_ctrl      (voice),
        .i_wave_byte (cur_byte),
        .o_sample    (sample)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dac_on    <= 1'b0;
            r_chan_on   <= 1'b0;
            r_len_en    <= 1'b0;
            r_len_cnt   <= 9'd0;
            r_vol       <= 2'd0;
            r_period    <= 11'd0;
            r_timer     <= 12'd0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < wsc_pkg::WAVE_BYTES; i++) begin
                r_wave[i] <= 8'd0;
            end
        end else begin
            if (accept) begin
                r_dac_on  <= n_dac_on;
                r_chan_on <= n_chan_on;
                r_len_en  <= n_len_en;
                r_len_cnt <= n_len_cnt;
                r_vol     <= n_vol;
                r_period  <= n_period;
                r_timer   <= n_timer;
                r_pos     <= n_pos;
                if (wave_we) begin
                    r_wave[item.reg_address[AW-1:0]] <= item.write_data;
                end
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result beat payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out.read_data      <= rd_data;
            r_out.sample_out     <= sample;
            r_out.channel_active <= n_chan_on;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;
endmodule

>>> design/wsc_sample_out.sv
// picks the current wave nibble and scales it by the volume code
// depends on wsc_pkg
module wsc_sample_out (
    input  wsc_pkg::t_voice_ctrl i_ctrl,
    input  logic [7:0]           i_wave_byte,
    output logic [3:0]           o_sample
);
    logic [3:0] nib;

    always_comb begin
        // even positions take the low nibble
        nib = i_ctrl.position[0] ? i_wave_byte[7:4] : i_wave_byte[3:0];
        if (!(i_ctrl.dac_on && i_ctrl.channel_on)) begin
            o_sample = 4'd0;
        end else begin
            case (i_ctrl.volume_code)
                2'd1:    o_sample = nib;
                2'd2:    o_sample = {1'b0, nib[3:1]};
                2'd3:    o_sample = {2'b00, nib[3:2]};
                default: o_sample = 4'd0;
            endcase
        end
    end
endmodule

>>> verif/wsc_channel_checker.sv
`timescale 1ns / 100ps
// result checker for the wavetable sound channel: predicts every result beat
// from the accepted action beats and compares field by field; uses wsc_pkg
module wsc_channel_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  wsc_pkg::t_in_item  i_in_beat,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  wsc_pkg::t_out_item i_out_beat,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam logic [1:0] VOL_MUTE = 2'd0;
    localparam logic [1:0] VOL_FULL = 2'd1;
    localparam logic [1:0] VOL_HALF = 2'd2;

    logic                      dac_on;
    logic                      channel_on;
    logic                      length_enable;
    logic [8:0]                length_count;
    logic [1:0]                volume_code;
    logic [10:0]               period_value;
    logic [11:0]               period_timer;
    logic [wsc_pkg::POS_W-1:0] position;
    logic [7:0]                wave_mem [wsc_pkg::WAVE_BYTES];

    wsc_pkg::t_out_item expected_results[$];

    // advance the channel by one action and work out the result beat it gives
    task automatic apply_action(input wsc_pkg::t_in_item beat,
                                output wsc_pkg::t_out_item res);
        logic [12:0] reload;
        logic [7:0]  addr;
        logic [7:0]  data;
        logic [7:0]  wave_byte;
        logic [3:0]  nibble;
        addr = beat.reg_address;
        data = beat.write_data;
        res.read_data = wsc_pkg::READ_IDLE;
        case (wsc_pkg::t_action'(beat.action))
            wsc_pkg::ACT_READ: begin
                case (addr)
                    wsc_pkg::ADDR_DAC:     res.read_data = {dac_on, 7'h7F};
                    wsc_pkg::ADDR_VOLUME:  res.read_data = {1'b1, volume_code, 5'h1F};
                    wsc_pkg::ADDR_FREQ_HI: res.read_data = {1'b1, length_enable, 6'h3F};
                    default: begin
                        if (addr >= wsc_pkg::ADDR_WAVE_LO && addr <= wsc_pkg::ADDR_WAVE_HI)
                            res.read_data = wave_mem[addr[wsc_pkg::WAVE_AW-1:0]];
                    end
                endcase
            end
            wsc_pkg::ACT_WRITE: begin
                case (addr)
                    wsc_pkg::ADDR_DAC: begin
                        dac_on = data[7];
                        if (!data[7])
                            channel_on = 1'b0;
                    end
                    wsc_pkg::ADDR_LENGTH:  length_count = wsc_pkg::LENGTH_FULL - 9'(data);
                    wsc_pkg::ADDR_VOLUME:  volume_code = data[6:5];
                    wsc_pkg::ADDR_FREQ_LO: period_value[7:0] = data;
                    wsc_pkg::ADDR_FREQ_HI: begin
                        period_value[10:8] = data[2:0];
                        length_enable = data[6];
                        // trigger only counts while the dac is on
                        if (data[7] && dac_on) begin
                            channel_on = 1'b1;
                            if (length_count == '0)
                                length_count = wsc_pkg::LENGTH_FULL;
                        end
                    end
                    default: begin
                        if (addr >= wsc_pkg::ADDR_WAVE_LO && addr <= wsc_pkg::ADDR_WAVE_HI)
                            wave_mem[addr[wsc_pkg::WAVE_AW-1:0]] = data;
                    end
                endcase
            end
            wsc_pkg::ACT_TICK: begin
                if (period_timer == '0) begin
                    // period zero reloads 4096, which wraps to 4095 after the decrement
                    reload = (13'(wsc_pkg::PERIOD_BASE) - 13'(period_value)) << 1;
                    position = position + 1'b1;
                    period_timer = reload[11:0] - 12'd1;
                end else begin
                    period_timer = period_timer - 12'd1;
                end
            end
            wsc_pkg::ACT_LENGTH: begin
                if (length_enable && length_count != '0) begin
                    length_count = length_count - 9'd1;
                    if (length_count == '0)
                        channel_on = 1'b0;
                end
            end
            default: ;
        endcase
        wave_byte = wave_mem[position[wsc_pkg::POS_W-1:1]];
        nibble = position[0] ? wave_byte[7:4] : wave_byte[3:0];
        if (!(dac_on && channel_on))
            res.sample_out = '0;
        else begin
            case (volume_code)
                VOL_MUTE: res.sample_out = '0;
                VOL_FULL: res.sample_out = nibble;
                VOL_HALF: res.sample_out = nibble >> 1;
                default:  res.sample_out = nibble >> 2;
            endcase
        end
        res.channel_active = channel_on;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin : watch
        wsc_pkg::t_out_item predicted;
        wsc_pkg::t_out_item expected;
        if (!i_rst_n) begin
            dac_on = 1'b0;
            channel_on = 1'b0;
            length_enable = 1'b0;
            length_count = '0;
            volume_code = '0;
            period_value = '0;
            period_timer = '0;
            position = '0;
            foreach (wave_mem[i])
                wave_mem[i] = '0;
            expected_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                apply_action(i_in_beat, predicted);
                expected_results.push_back(predicted);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, i_out_beat);
                    o_fail_count++;
                end else begin
                    expected = expected_results.pop_front();
                    if (i_out_beat.read_data !== expected.read_data) begin
                        $display("%0t: read_data expected %h, got %h", $time,
                                 expected.read_data, i_out_beat.read_data);
                        o_fail_count++;
                    end
                    if (i_out_beat.sample_out !== expected.sample_out) begin
                        $display("%0t: sample_out expected %h, got %h", $time,
                                 expected.sample_out, i_out_beat.sample_out);
                        o_fail_count++;
                    end
                    if (i_out_beat.channel_active !== expected.channel_active) begin
                        $display("%0t: channel_active expected %b, got %b", $time,
                                 expected.channel_active, i_out_beat.channel_active);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

>>> verif/tb_wavetable_sound_channel.sv
`timescale 1ns / 100ps
// top of the wavetable sound channel testbench: clock, reset, action beats and
// result back-pressure; depends on wsc_pkg, wsc_stream_if, wavetable_sound_channel and wsc_channel_checker
module tb_wavetable_sound_channel;

    localparam int RESET_CYCLES   = 7;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int RANDOM_ITEMS   = 1030;
    localparam int TAIL_TICKS     = 40;
    localparam int LONG_HOLD      = 300;
    localparam int LONG_HOLD_AT   = 600;
    localparam int SETTLE_CYCLES  = 10;

    localparam logic [7:0] ADDR_UNMAPPED_LO = 8'h00;
    localparam logic [7:0] ADDR_UNMAPPED_HI = 8'hFF;

    logic clk = 1'b0;
    logic rst_n;
    int   cycle_count = 0;
    int   beats_sent = 0;
    int   send_steady = 0;
    int   fail_count;
    int   results_pending;

    wsc_stream_if #(.t_payload(wsc_pkg::t_in_item))  action_if ();
    wsc_stream_if #(.t_payload(wsc_pkg::t_out_item)) result_if ();

    wavetable_sound_channel u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (action_if),
        .o_out   (result_if)
    );

    wsc_channel_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (action_if.valid),
        .i_in_ready   (action_if.ready),
        .i_in_beat    (action_if.payload),
        .i_out_valid  (result_if.valid),
        .i_out_ready  (result_if.ready),
        .i_out_beat   (result_if.payload),
        .o_fail_count (fail_count),
        .o_pending    (results_pending)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // offer one action beat after a random gap and hold it until accepted
    task automatic send_beat(input wsc_pkg::t_action act, input logic [7:0] addr,
                             input logic [7:0] data);
        int gap;
        int pick;
        gap = 0;
        if (send_steady > 0) begin
            send_steady--;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick >= 50 && pick < 65)
                send_steady = $urandom_range(10, 60);
            else if (pick >= 65 && pick < 95)
                gap = $urandom_range(1, 3);
            else if (pick >= 95)
                gap = $urandom_range(8, 30);
        end
        repeat (gap) begin
            @(negedge clk);
            action_if.valid = 1'b0;
        end
        @(negedge clk);
        action_if.valid = 1'b1;
        action_if.payload = '{action: act, reg_address: addr, write_data: data};
        do @(posedge clk); while (!action_if.ready);
        beats_sent++;
    endtask

    // mostly tick, length, register and wave traffic that keeps the voice sounding, some noise
    task automatic random_beat();
        int        pick;
        logic [7:0] data;
        pick = $urandom_range(0, 99);
        data = 8'($urandom);
        if (pick < 30) begin
            send_beat(wsc_pkg::ACT_TICK, 8'($urandom), data);
        end else if (pick < 40) begin
            send_beat(wsc_pkg::ACT_LENGTH, 8'($urandom), data);
        end else if (pick < 55) begin
            case ($urandom_range(0, 2))
                0: send_beat(wsc_pkg::ACT_READ,
                             8'(wsc_pkg::ADDR_DAC + 8'($urandom_range(0, 4))), data);
                1: send_beat(wsc_pkg::ACT_READ,
                             8'(wsc_pkg::ADDR_WAVE_LO + 8'($urandom_range(0, 15))), data);
                default: send_beat(wsc_pkg::ACT_READ, 8'($urandom), data);
            endcase
        end else if (pick < 88) begin
            case ($urandom_range(0, 5))
                0: send_beat(wsc_pkg::ACT_WRITE, wsc_pkg::ADDR_DAC,
                             ($urandom_range(0, 9) == 0) ? data : (data | 8'h80));
                1: send_beat(wsc_pkg::ACT_WRITE, wsc_pkg::ADDR_LENGTH,
                             ($urandom_range(0, 1) == 0) ? (data | 8'hF0) : data);
                2: send_beat(wsc_pkg::ACT_WRITE, wsc_pkg::ADDR_VOLUME, data);
                // short periods keep the wave position moving
                3: send_beat(wsc_pkg::ACT_WRITE, wsc_pkg::ADDR_FREQ_LO, data | 8'hF0);
                4: send_beat(wsc_pkg::ACT_WRITE, wsc_pkg::ADDR_FREQ_HI, data | 8'h07);
                default: send_beat(wsc_pkg::ACT_WRITE,
                                   8'(wsc_pkg::ADDR_WAVE_LO + 8'($urandom_range(0, 15))),
                                   data);
            endcase
        end else begin
            send_beat(wsc_pkg::t_action'($urandom_range(0, 3)), 8'($urandom), data);
        end
    endtask

    // result side: random stalls, steady stretches and one long hold-off
    initial begin : result_sink
        int hold_left;
        int steady_left;
        bit long_hold_done;
        int pick;
        hold_left = 0;
        steady_left = 0;
        long_hold_done = 1'b0;
        result_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                result_if.ready = 1'b0;
                hold_left--;
            end else if (!long_hold_done && beats_sent >= LONG_HOLD_AT) begin
                result_if.ready = 1'b0;
                hold_left = LONG_HOLD - 1;
                long_hold_done = 1'b1;
            end else if (steady_left > 0) begin
                result_if.ready = 1'b1;
                steady_left--;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    result_if.ready = 1'b1;
                end else if (pick < 70) begin
                    result_if.ready = 1'b1;
                    steady_left = $urandom_range(10, 60);
                end else if (pick < 95) begin
                    result_if.ready = 1'b0;
                    hold_left = $urandom_range(0, 2);
                end else begin
                    result_if.ready = 1'b0;
                    hold_left = $urandom_range(8, 40);
                end
            end
        end
    end

    initial begin
        rst_n = 1'b0;
        action_if.valid = 1'b0;
        action_if.payload = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        send_beat(wsc_pkg::ACT_WRITE, wsc_pkg::ADDR_FREQ_HI, 8'h80);  // trigger with dac off
        // shortest period so the position moves on every other tick
        send_beat(wsc_pkg::ACT_WRITE, wsc_pkg::ADDR_FREQ_LO, 8'hFF);
        send_beat(wsc_pkg::ACT_WRITE, wsc_pkg::ADDR_FREQ_HI, 8'h07);
        send_beat(wsc_pkg::ACT_TICK, 8'h00, 8'h00);

        send_beat(wsc_pkg::ACT_WRITE, wsc_pkg::ADDR_WAVE_LO, 8'hFF);
        send_beat(wsc_pkg::ACT_WRITE, wsc_pkg::ADDR_WAVE_HI, 8'h00);
        send_beat(wsc_pkg::ACT_WRITE, wsc_pkg::ADDR_DAC, 8'hFF);
        send_beat(wsc_pkg::ACT_WRITE, wsc_pkg::ADDR_VOLUME, 8'h20);
        send_beat(wsc_pkg::ACT_WRITE, wsc_pkg::ADDR_LENGTH, 8'hFE);
        send_beat(wsc_pkg::ACT_WRITE, wsc_pkg::ADDR_FREQ_HI, 8'hC7);
        send_beat(wsc_pkg::ACT_READ, wsc_pkg::ADDR_DAC, 8'h00);
        send_beat(wsc_pkg::ACT_READ, wsc_pkg::ADDR_LENGTH, 8'h00);
        send_beat(wsc_pkg::ACT_READ, wsc_pkg::ADDR_VOLUME, 8'h00);
        send_beat(wsc_pkg::ACT_READ, wsc_pkg::ADDR_FREQ_HI, 8'h00);
        send_beat(wsc_pkg::ACT_READ, wsc_pkg::ADDR_WAVE_LO, 8'h00);
        send_beat(wsc_pkg::ACT_READ, ADDR_UNMAPPED_HI, 8'h00);
        send_beat(wsc_pkg::ACT_WRITE, ADDR_UNMAPPED_LO, 8'hFF);
        send_beat(wsc_pkg::ACT_TICK, 8'h00, 8'h00);
        send_beat(wsc_pkg::ACT_TICK, 8'h00, 8'h00);
        send_beat(wsc_pkg::ACT_WRITE, wsc_pkg::ADDR_VOLUME, 8'h00);
        send_beat(wsc_pkg::ACT_WRITE, wsc_pkg::ADDR_VOLUME, 8'h60);
        send_beat(wsc_pkg::ACT_LENGTH, 8'h00, 8'h00);
        send_beat(wsc_pkg::ACT_LENGTH, 8'h00, 8'h00);            // count runs out here
        send_beat(wsc_pkg::ACT_LENGTH, 8'h00, 8'h00);            // already at zero
        send_beat(wsc_pkg::ACT_WRITE, wsc_pkg::ADDR_FREQ_HI, 8'h87);  // trigger reloads 256
        send_beat(wsc_pkg::ACT_WRITE, wsc_pkg::ADDR_DAC, 8'h00);

        repeat (RANDOM_ITEMS) random_beat();

        // period zero: the timer runs out and reloads 4096
        send_beat(wsc_pkg::ACT_WRITE, wsc_pkg::ADDR_FREQ_LO, 8'h00);
        send_beat(wsc_pkg::ACT_WRITE, wsc_pkg::ADDR_DAC, 8'h80);
        send_beat(wsc_pkg::ACT_WRITE, wsc_pkg::ADDR_VOLUME, 8'h20);
        send_beat(wsc_pkg::ACT_WRITE, wsc_pkg::ADDR_FREQ_HI, 8'h80);
        repeat (TAIL_TICKS) send_beat(wsc_pkg::ACT_TICK, 8'($urandom), 8'($urandom));

        @(negedge clk);
        action_if.valid = 1'b0;

        wait (results_pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && results_pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> wavetable_sound_channel.f
design/wsc_pkg.sv
design/wsc_stream_if.sv
design/wsc_sample_out.sv
design/wavetable_sound_channel.sv
verif/wsc_channel_checker.sv
verif/tb_wavetable_sound_channel.sv
